FILE: hw/rtl/ucdc_pkg.sv
// ----------------------------------------------------------------------------
// ucdc_pkg
// Shared types, character constants and helpers for the URL percent codec.
// ----------------------------------------------------------------------------
package ucdc_pkg;

  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LZ     = 8'h7A;

  localparam logic DIR_DECODE = 1'b0;
  localparam logic DIR_ENCODE = 1'b1;

  // Output bytes produced by one input byte
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] chars;
    logic            text_end;
  } ucdc_group_t;

  // {valid, value}; value is zero when not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_0 && c <= CH_9) begin
      r = {1'b1, 4'(c - CH_0)};
    end else if (c >= CH_LA && c <= CH_LF) begin
      r = {1'b1, 4'(c - CH_LA + 8'd10)};
    end else if (c >= CH_UA && c <= CH_UF) begin
      r = {1'b1, 4'(c - CH_UA + 8'd10)};
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = CH_0 + {4'd0, n};
    end else begin
      r = CH_UA + {4'd0, n} - 8'd10;
    end
    return r;
  endfunction

  function automatic logic passes_plain(input logic [7:0] c);
    return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ) ||
           (c >= CH_0 && c <= CH_9) || c == CH_DASH || c == CH_USCORE ||
           c == CH_DOT;
  endfunction

endpackage

FILE: hw/rtl/ucdc_front.sv
// ----------------------------------------------------------------------------
// ucdc_front
// Accepts input bytes, tracks escape state and builds the output group.
// ----------------------------------------------------------------------------
module ucdc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               direction,
  input  logic               cfg_wr_en,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char,
  input  logic               in_text_end,
  input  logic               q_full,
  output logic               q_push,
  output ucdc_pkg::ucdc_group_t q_data,
  output logic               esc_idle
);
  import ucdc_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_PCT   = 3'b010,
    PH_DIGIT = 3'b100
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [7:0]      held_r, held_nxt;
  logic [3:0][7:0] buf_v;
  logic [2:0]      n_v;
  logic            do_fresh;
  logic [4:0]      hv;
  logic [3:0]      hh;
  logic            accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign hv       = hex_val(in_char);
  assign hh       = 4'(hex_val(held_r));
  assign esc_idle = (phase_r == PH_IDLE);

  always_comb begin
    buf_v     = '0;
    n_v       = 3'd0;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    do_fresh  = 1'b0;
    if (direction == DIR_ENCODE) begin
      if (passes_plain(in_char)) begin
        buf_v[0] = in_char;
        n_v      = 3'd1;
      end else if (in_char == CH_SPACE) begin
        buf_v[0] = CH_PLUS;
        n_v      = 3'd1;
      end else begin
        buf_v[0] = CH_PCT;
        buf_v[1] = hex_digit(in_char[7:4]);
        buf_v[2] = hex_digit(in_char[3:0]);
        n_v      = 3'd3;
      end
    end else begin
      unique case (phase_r)
        PH_PCT: begin
          if (hv[4]) begin
            held_nxt  = in_char;
            phase_nxt = PH_DIGIT;
          end else begin
            buf_v[0] = CH_PCT;
            n_v      = 3'd1;
            do_fresh = 1'b1;
          end
        end
        PH_DIGIT: begin
          if (hv[4]) begin
            buf_v[0]  = {hh, hv[3:0]};
            n_v       = 3'd1;
            phase_nxt = PH_IDLE;
          end else begin
            buf_v[0] = CH_PCT;
            buf_v[1] = held_r;
            n_v      = 3'd2;
            do_fresh = 1'b1;
          end
        end
        default: do_fresh = 1'b1;
      endcase
      if (do_fresh) begin
        if (in_char == CH_PCT) begin
          phase_nxt = PH_PCT;
        end else begin
          buf_v[n_v[1:0]] = (in_char == CH_PLUS) ? CH_SPACE : in_char;
          n_v             = n_v + 3'd1;
          phase_nxt       = PH_IDLE;
        end
      end
      if (in_text_end) begin
        if (phase_nxt == PH_PCT) begin
          buf_v[n_v[1:0]] = CH_PCT;
          n_v             = n_v + 3'd1;
        end else if (phase_nxt == PH_DIGIT) begin
          buf_v[n_v[1:0]] = CH_PCT;
          buf_v[2'(n_v + 3'd1)] = held_nxt;
          n_v             = n_v + 3'd2;
        end
        phase_nxt = PH_IDLE;
        held_nxt  = 8'd0;
      end
    end
  end

  assign q_data.cnt      = (n_v > 3'd3) ? 2'd3 : n_v[1:0];
  assign q_data.chars    = buf_v[2:0];
  assign q_data.text_end = in_text_end;
  assign q_push          = accept && (n_v != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr_en) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

FILE: hw/rtl/ucdc_queue.sv
// ----------------------------------------------------------------------------
// ucdc_queue
// Small FIFO of output groups between front and back.
// ----------------------------------------------------------------------------
module ucdc_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ucdc_pkg::ucdc_group_t push_data,
  input  logic                  pop,
  output ucdc_pkg::ucdc_group_t head,
  output logic                  full,
  output logic                  nonempty
);
  import ucdc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ucdc_group_t    mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign nonempty = (count_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign head     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/ucdc_back.sv
// ----------------------------------------------------------------------------
// ucdc_back
// Serializes queued groups into one output byte per transaction.
// ----------------------------------------------------------------------------
module ucdc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ucdc_pkg::ucdc_group_t head,
  input  logic                  q_nonempty,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_char,
  output logic                  out_run_last,
  output logic                  out_text_done
);
  import ucdc_pkg::*;

  logic [1:0] idx_r;
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_run_last_r;
  logic       out_text_done_r;
  logic       load;
  logic       last;
  logic [7:0] sel_char;

  assign load  = q_nonempty && (!out_valid_r || out_ready);
  assign last  = (idx_r == head.cnt - 2'd1);
  assign q_pop = load && last;

  always_comb begin
    case (idx_r)
      2'd1:    sel_char = head.chars[1];
      2'd2:    sel_char = head.chars[2];
      default: sel_char = head.chars[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= last ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r      <= sel_char;
      out_run_last_r  <= last;
      out_text_done_r <= last && head.text_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_run_last  = out_run_last_r;
  assign out_text_done = out_text_done_r;

endmodule

FILE: hw/rtl/url_percent_codec.sv
// First output byte: the input group is registered in the group queue, then in the output register.
// Throughput: one output byte per cycle from the single output register while
//   a group is queued and out_ready holds; an input byte yields 0 to 3 bytes.
// Input stalls only when the group queue between front and back is full.
// Reset (rst_n, synchronous): direction decode, escape state idle, queue and
//   output empty.
// ----------------------------------------------------------------------------
// url_percent_codec
// Byte-stream URL percent encoder/decoder with a direction register.
// ----------------------------------------------------------------------------
module url_percent_codec #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_text_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_run_last,
  output logic       out_text_done
);
  import ucdc_pkg::*;

  logic        direction_r;
  ucdc_group_t push_data;
  ucdc_group_t head;
  logic        q_push, q_pop, q_full, q_nonempty;
  logic        esc_idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_DECODE;
    end else if (cfg_wr_en) begin
      direction_r <= cfg_wr_data;
    end
  end

  ucdc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .direction   (direction_r),
    .cfg_wr_en   (cfg_wr_en),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_char     (in_char),
    .in_text_end (in_text_end),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (push_data),
    .esc_idle    (esc_idle)
  );

  ucdc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .head      (head),
    .full      (q_full),
    .nonempty  (q_nonempty)
  );

  ucdc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_nonempty    (q_nonempty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .out_run_last  (out_run_last),
    .out_text_done (out_text_done)
  );

  // end of text flushes any pending escape
  a_end_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_text_end && !cfg_wr_en) |=> esc_idle)
    else $error("escape state not idle after end of text");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_text_done) |-> out_run_last)
    else $error("text_done without run_last");

  a_out_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(q_nonempty))
    else $error("output transaction without queued group");

  a_encode_holds_esc: assert property (@(posedge clk) disable iff (!rst_n)
    (direction_r == DIR_ENCODE && !cfg_wr_en && esc_idle) |=> esc_idle)
    else $error("escape state changed while encoding");

endmodule

FILE: tb/sv/url_percent_codec_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// url_percent_codec_checker
// Watches the config port and both streams of the URL percent codec. For each
// input transaction it works out the output bytes it must produce, queues
// them, and compares every output transaction against the oldest one.
// ----------------------------------------------------------------------------
module url_percent_codec_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_text_end,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_char,
  input  logic       out_run_last,
  input  logic       out_text_done,
  output int         mismatches,
  output int         outstanding
);
  import ucdc_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       text_done;
  } out_byte_t;

  out_byte_t  pending_bytes_q[$];
  logic [7:0] staged_q[$];
  logic       dir_mode;
  logic [1:0] esc_phase;
  logic [7:0] held_digit;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic int hex_nibble(input logic [7:0] c);
    int r;
    r = -1;
    if (c >= CH_0 && c <= CH_9) r = int'(c) - int'(CH_0);
    else if (c >= CH_UA && c <= CH_UF) r = int'(c) - int'(CH_UA) + 10;
    else if (c >= CH_LA && c <= CH_LF) r = int'(c) - int'(CH_LA) + 10;
    return r;
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) r = CH_0 + {4'd0, n};
    else r = CH_UA + {4'd0, n} - 8'd10;
    return r;
  endfunction

  function automatic logic unreserved(input logic [7:0] c);
    logic r;
    r = (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
        (c >= CH_LA && c <= CH_LZ);
    return r || c == CH_DASH || c == CH_USCORE || c == CH_DOT;
  endfunction

  // plain text handling outside an escape
  task automatic stage_fresh(input logic [7:0] c);
    if (c == CH_PCT) esc_phase = PH_PCT;
    else if (c == CH_PLUS) staged_q.push_back(CH_SPACE);
    else staged_q.push_back(c);
  endtask

  task automatic predict_conversion(input logic [7:0] c, input logic fin);
    int        v;
    int        h;
    int        n;
    out_byte_t ob;
    staged_q.delete();
    if (dir_mode == DIR_ENCODE) begin
      if (unreserved(c)) begin
        staged_q.push_back(c);
      end else if (c == CH_SPACE) begin
        staged_q.push_back(CH_PLUS);
      end else begin
        staged_q.push_back(CH_PCT);
        staged_q.push_back(nibble_char(c[7:4]));
        staged_q.push_back(nibble_char(c[3:0]));
      end
    end else begin
      v = hex_nibble(c);
      case (esc_phase)
        PH_PCT: begin
          if (v >= 0) begin
            held_digit = c;
            esc_phase  = PH_DIGIT;
          end else begin
            staged_q.push_back(CH_PCT);
            esc_phase = PH_IDLE;
            stage_fresh(c);
          end
        end
        PH_DIGIT: begin
          if (v >= 0) begin
            h = hex_nibble(held_digit);
            if (h < 0) h = 0;
            staged_q.push_back({h[3:0], v[3:0]});
            esc_phase = PH_IDLE;
          end else begin
            staged_q.push_back(CH_PCT);
            staged_q.push_back(held_digit);
            esc_phase = PH_IDLE;
            stage_fresh(c);
          end
        end
        default: begin
          esc_phase = PH_IDLE;
          stage_fresh(c);
        end
      endcase
      if (fin) begin
        if (esc_phase == PH_PCT) begin
          staged_q.push_back(CH_PCT);
        end else if (esc_phase == PH_DIGIT) begin
          staged_q.push_back(CH_PCT);
          staged_q.push_back(held_digit);
        end
        esc_phase  = PH_IDLE;
        held_digit = 8'd0;
      end
    end
    n = staged_q.size();
    if (n > 3) n = 3;
    for (int k = 0; k < n; k++) begin
      ob.ch        = staged_q[k];
      ob.run_last  = (k == n - 1);
      ob.text_done = (k == n - 1) && fin;
      pending_bytes_q.push_back(ob);
    end
  endtask

  task automatic flag_error(input logic have_want, input out_byte_t want);
    if (mismatches < 10) begin
      if (have_want)
        $display("mismatch: expected char %h last %b done %b, got char %h last %b done %b",
                 want.ch, want.run_last, want.text_done,
                 out_char, out_run_last, out_text_done);
      else
        $display("mismatch: unexpected output char %h last %b done %b",
                 out_char, out_run_last, out_text_done);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    out_byte_t want;
    if (!rst_n) begin
      dir_mode   = DIR_DECODE;
      esc_phase  = PH_IDLE;
      held_digit = 8'd0;
      pending_bytes_q.delete();
    end else begin
      if (cfg_wr_en) begin
        dir_mode   = cfg_wr_data;
        esc_phase  = PH_IDLE;
        held_digit = 8'd0;
      end
      if (out_valid && out_ready) begin
        if (pending_bytes_q.size() == 0) begin
          want = '0;
          flag_error(1'b0, want);
        end else begin
          want = pending_bytes_q.pop_front();
          if (want.ch !== out_char || want.run_last !== out_run_last ||
              want.text_done !== out_text_done)
            flag_error(1'b1, want);
        end
      end
      if (in_valid && in_ready) predict_conversion(in_char, in_text_end);
    end
    outstanding = pending_bytes_q.size();
  end

endmodule

FILE: tb/sv/url_percent_codec_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// url_percent_codec_tb
// Drives the URL percent codec with directed decode and encode texts, then
// random texts in alternating directions, with random idling on both streams
// and one long output hold-off. A checker module predicts and compares.
// ----------------------------------------------------------------------------
module url_percent_codec_tb;
  import ucdc_pkg::*;

  localparam int RANDOM_ITEMS   = 430;
  localparam int IDLE_PCT       = 12;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_AFTER     = 120;
  localparam int HOLD_CYCLES    = 300;
  localparam int TIMEOUT_CYCLES = 200000;

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic       cfg_wr_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_char;
  logic       in_text_end;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_char;
  logic       out_run_last;
  logic       out_text_done;

  int         mismatches;
  int         outstanding;
  int         items_sent;
  int         cycle_count;
  logic [7:0] text_q[$];

  url_percent_codec u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char      (in_char),
    .in_text_end  (in_text_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_run_last (out_run_last),
    .out_text_done(out_text_done)
  );

  url_percent_codec_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char      (in_char),
    .in_text_end  (in_text_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_run_last (out_run_last),
    .out_text_done(out_text_done),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < TIMEOUT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // output side: random backpressure, one long hold-off, one quiet stretch
  initial begin : rx_side
    int   got;
    logic held;
    got       = 0;
    held      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) got++;
      if (!held && got >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end
      if (got >= 500 && got < 800) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int idle;
    idle = (items_sent >= 200 && items_sent < 320) ? 0 : IDLE_PCT;
    while ($urandom_range(99) < idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_char     <= b;
    in_text_end <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(input logic d);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= d;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return CH_0 + 8'(v);
    if ($urandom_range(1)) return CH_UA + 8'(v - 10);
    return CH_LA + 8'(v - 10);
  endfunction

  function automatic logic [7:0] rand_non_hex();
    if ($urandom_range(1)) return 8'h67 + 8'($urandom_range(19));
    return 8'($urandom_range(8'h2F));
  endfunction

  // one decode token: well formed escapes most often, some noise
  task automatic add_token();
    int kind;
    kind = $urandom_range(9);
    case (kind)
      0, 1, 2, 3: begin
        text_q.push_back(CH_PCT);
        text_q.push_back(rand_hex_char());
        text_q.push_back(rand_hex_char());
      end
      4: text_q.push_back(CH_PLUS);
      5: text_q.push_back(8'($urandom_range(255)));
      6: begin
        text_q.push_back(CH_PCT);
        text_q.push_back(rand_non_hex());
      end
      7: begin
        text_q.push_back(CH_PCT);
        text_q.push_back(rand_hex_char());
        text_q.push_back(rand_non_hex());
      end
      8: text_q.push_back(CH_PCT);
      default: text_q.push_back(CH_LA + 8'($urandom_range(25)));
    endcase
  endtask

  task automatic send_text(input logic d);
    int n;
    text_q.delete();
    if (d == DIR_ENCODE) begin
      n = $urandom_range(1, 10);
      repeat (n) text_q.push_back(8'($urandom_range(255)));
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) add_token();
    end
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  initial begin : stimulus
    logic d;
    int   random_start;
    int   phase_end;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid    = 1'b0;
    in_char     = 8'd0;
    in_text_end = 1'b0;
    items_sent  = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // decode: escapes in both cases, plus, cut escapes, end inside escape
    send_byte(CH_PCT, 1'b0); send_byte("4", 1'b0); send_byte("1", 1'b0);
    send_byte(CH_PCT, 1'b0); send_byte("f", 1'b0); send_byte("F", 1'b0);
    send_byte(CH_PLUS, 1'b0);
    send_byte(CH_PCT, 1'b0); send_byte("G", 1'b0);
    send_byte(CH_PCT, 1'b0); send_byte("4", 1'b0); send_byte(CH_PLUS, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_PCT, 1'b0); send_byte("a", 1'b1);
    send_byte(CH_PCT, 1'b1);
    // escape left pending, dropped by the direction write
    send_byte(CH_PCT, 1'b0); send_byte("7", 1'b0);
    write_direction(DIR_ENCODE);
    send_byte("Z", 1'b0); send_byte("a", 1'b0); send_byte("9", 1'b0);
    send_byte(CH_DASH, 1'b0); send_byte(CH_USCORE, 1'b0); send_byte(CH_DOT, 1'b0);
    send_byte(CH_SPACE, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(CH_PCT, 1'b1);

    d = DIR_DECODE;
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      write_direction(d);
      phase_end = items_sent + $urandom_range(30, 70);
      while (items_sent < phase_end && items_sent - random_start < RANDOM_ITEMS)
        send_text(d);
      d = ~d;
    end

    wait_drained();
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
